// ----- rtl/cau_pkg.sv -----
package cau_pkg;

    localparam int PART_W = 16;
    localparam int FRAC_W = 8;
    localparam int PROD_W = 2 * PART_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int REM_W  = PROD_W + FRAC_W;
    localparam int QUO_W  = PART_W + 2;
    localparam int CMP_W  = 3 * PART_W + 2;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                      command;
        logic signed [PART_W-1:0] a_real;
        logic signed [PART_W-1:0] a_imag;
        logic signed [PART_W-1:0] b_real;
        logic signed [PART_W-1:0] b_imag;
    } t_in;

    typedef struct packed {
        logic signed [PART_W-1:0] res_real;
        logic signed [PART_W-1:0] res_imag;
        logic                     overflow;
        logic                     div_zero;
    } t_out;

    // sign/magnitude item moving down the divider stages
    typedef struct packed {
        logic               vld;
        t_cmd               cmd;
        logic               dz;
        logic               neg_re;
        logic               neg_im;
        logic [REM_W-1:0]   rem_re;
        logic [REM_W-1:0]   rem_im;
        logic [PROD_W-1:0]  den;
        logic [QUO_W-1:0]   q_re;
        logic [QUO_W-1:0]   q_im;
    } t_pipe;

endpackage

// ----- rtl/cau_front.sv -----
module cau_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  cau_pkg::t_in  i_item,
    output cau_pkg::t_pipe o_pipe
);
    import cau_pkg::*;

    // stage A: products and plain sums
    logic                     r_a_vld;
    t_cmd                     r_a_cmd;
    logic signed [PROD_W-1:0] r_p0, r_p1, r_p2, r_p3, r_sq0, r_sq1;
    logic signed [PART_W:0]   r_s_re, r_s_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_cmd <= i_item.command;
        r_p0    <= i_item.a_real * i_item.b_real;
        r_p1    <= i_item.a_imag * i_item.b_imag;
        r_p2    <= i_item.a_imag * i_item.b_real;
        r_p3    <= i_item.a_real * i_item.b_imag;
        r_sq0   <= i_item.b_real * i_item.b_real;
        r_sq1   <= i_item.b_imag * i_item.b_imag;
        if (i_item.command == CMD_SUB) begin
            r_s_re <= {i_item.a_real[PART_W-1], i_item.a_real}
                    - {i_item.b_real[PART_W-1], i_item.b_real};
            r_s_im <= {i_item.a_imag[PART_W-1], i_item.a_imag}
                    - {i_item.b_imag[PART_W-1], i_item.b_imag};
        end else begin
            r_s_re <= {i_item.a_real[PART_W-1], i_item.a_real}
                    + {i_item.b_real[PART_W-1], i_item.b_real};
            r_s_im <= {i_item.a_imag[PART_W-1], i_item.a_imag}
                    + {i_item.b_imag[PART_W-1], i_item.b_imag};
        end
    end

    // stage B: combine, convert to sign/magnitude
    logic signed [SUM_W-1:0] n_v_re, n_v_im;
    logic [SUM_W-1:0]        n_abs_re, n_abs_im;
    logic [PROD_W-1:0]       n_mag_re, n_mag_im, n_den;
    t_pipe                   n_pipe, r_pipe;

    always_comb begin
        case (r_a_cmd)
            CMD_MUL: begin
                n_v_re = SUM_W'(r_p0) - SUM_W'(r_p1);
                n_v_im = SUM_W'(r_p2) + SUM_W'(r_p3);
            end
            CMD_DIV: begin
                n_v_re = SUM_W'(r_p0) + SUM_W'(r_p1);
                n_v_im = SUM_W'(r_p2) - SUM_W'(r_p3);
            end
            default: begin
                n_v_re = SUM_W'(r_s_re);
                n_v_im = SUM_W'(r_s_im);
            end
        endcase
        n_abs_re = n_v_re[SUM_W-1] ? SUM_W'(-n_v_re) : SUM_W'(n_v_re);
        n_abs_im = n_v_im[SUM_W-1] ? SUM_W'(-n_v_im) : SUM_W'(n_v_im);
        n_mag_re = n_abs_re[PROD_W-1:0];
        n_mag_im = n_abs_im[PROD_W-1:0];
        n_den    = r_sq0[PROD_W-1:0] + r_sq1[PROD_W-1:0];

        n_pipe        = '0;
        n_pipe.vld    = r_a_vld;
        n_pipe.cmd    = r_a_cmd;
        n_pipe.neg_re = n_v_re[SUM_W-1];
        n_pipe.neg_im = n_v_im[SUM_W-1];
        n_pipe.den    = n_den;
        n_pipe.dz     = (r_a_cmd == CMD_DIV) && (n_den == '0);
        case (r_a_cmd)
            CMD_MUL: begin
                // magnitude truncation drops fraction toward zero
                n_pipe.rem_re = REM_W'(n_mag_re >> FRAC_W);
                n_pipe.rem_im = REM_W'(n_mag_im >> FRAC_W);
            end
            CMD_DIV: begin
                n_pipe.rem_re = REM_W'(n_mag_re) << FRAC_W;
                n_pipe.rem_im = REM_W'(n_mag_im) << FRAC_W;
            end
            default: begin
                n_pipe.rem_re = REM_W'(n_mag_re);
                n_pipe.rem_im = REM_W'(n_mag_im);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe.vld <= 1'b0;
        end else begin
            r_pipe.vld <= n_pipe.vld;
        end
        r_pipe.cmd    <= n_pipe.cmd;
        r_pipe.dz     <= n_pipe.dz;
        r_pipe.neg_re <= n_pipe.neg_re;
        r_pipe.neg_im <= n_pipe.neg_im;
        r_pipe.rem_re <= n_pipe.rem_re;
        r_pipe.rem_im <= n_pipe.rem_im;
        r_pipe.den    <= n_pipe.den;
        r_pipe.q_re   <= n_pipe.q_re;
        r_pipe.q_im   <= n_pipe.q_im;
    end

    assign o_pipe = r_pipe;

endmodule

// ----- rtl/cau_div_stage.sv -----
module cau_div_stage #(
    parameter int K = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cau_pkg::t_pipe i_pipe,
    output cau_pkg::t_pipe o_pipe
);
    import cau_pkg::*;

    logic [CMP_W-1:0] n_trial, n_rem_re_x, n_rem_im_x;
    logic             n_ge_re, n_ge_im, n_div;
    t_pipe            n_pipe, r_pipe;

    // one restoring step: quotient bit K of both parts
    always_comb begin
        n_div      = (i_pipe.cmd == CMD_DIV);
        n_trial    = CMP_W'(i_pipe.den) << K;
        n_rem_re_x = CMP_W'(i_pipe.rem_re);
        n_rem_im_x = CMP_W'(i_pipe.rem_im);
        n_ge_re    = n_div && (n_rem_re_x >= n_trial);
        n_ge_im    = n_div && (n_rem_im_x >= n_trial);
        n_pipe     = i_pipe;
        if (n_ge_re) begin
            n_pipe.rem_re  = i_pipe.rem_re - n_trial[REM_W-1:0];
            n_pipe.q_re[K] = 1'b1;
        end
        if (n_ge_im) begin
            n_pipe.rem_im  = i_pipe.rem_im - n_trial[REM_W-1:0];
            n_pipe.q_im[K] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe.vld <= 1'b0;
        end else begin
            r_pipe.vld <= n_pipe.vld;
        end
        r_pipe.cmd    <= n_pipe.cmd;
        r_pipe.dz     <= n_pipe.dz;
        r_pipe.neg_re <= n_pipe.neg_re;
        r_pipe.neg_im <= n_pipe.neg_im;
        r_pipe.rem_re <= n_pipe.rem_re;
        r_pipe.rem_im <= n_pipe.rem_im;
        r_pipe.den    <= n_pipe.den;
        r_pipe.q_re   <= n_pipe.q_re;
        r_pipe.q_im   <= n_pipe.q_im;
    end

    assign o_pipe = r_pipe;

endmodule

// ----- rtl/complex_arithmetic_unit.sv -----
// channel  | handshake          | payload
// ---------+--------------------+-------------------------------
// command  | i_start, o_busy    | i_item  (cau_pkg::t_in)
// result   | o_strobe           | o_res   (cau_pkg::t_out)
//
// Fully pipelined: one item per cycle, o_busy stays low.
// Parts are Q8.8. Pipeline: two front stages (products and sums, then combine
// to sign/magnitude), PART_W + 2 restoring divider steps, one saturate stage.
// Every command runs the full depth so results leave in order.
// Synchronous active-low reset clears the valid bits only.
// The receiver cannot stall; each result strobes for one cycle.
module complex_arithmetic_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  cau_pkg::t_in  i_item,
    output logic          o_busy,
    output logic          o_strobe,
    output cau_pkg::t_out o_res
);
    import cau_pkg::*;

    localparam logic [REM_W-1:0] HALF = REM_W'(1) << (PART_W - 1);

    t_pipe w_pipe [QUO_W+1];

    assign o_busy = 1'b0;

    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_start),
        .i_item  (i_item),
        .o_pipe  (w_pipe[0])
    );

    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        cau_div_stage #(.K(QUO_W - 1 - g)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pipe  (w_pipe[g]),
            .o_pipe  (w_pipe[g+1])
        );
    end

    t_pipe            w_last;
    logic [REM_W-1:0] n_mag_re, n_mag_im;
    logic             n_ovf_re, n_ovf_im;
    t_out             n_res, r_res;
    logic             r_strobe;

    function automatic logic [PART_W-1:0] sat_part(input logic neg,
                                                  input logic [REM_W-1:0] mag,
                                                  output logic ovf);
        logic [REM_W-1:0] t;
        t   = '0;
        ovf = 1'b0;
        if (neg) begin
            if (mag > HALF) begin
                ovf = 1'b1;
                t   = HALF;
            end else begin
                t = -mag;
            end
        end else begin
            if (mag > HALF - REM_W'(1)) begin
                ovf = 1'b1;
                t   = HALF - REM_W'(1);
            end else begin
                t = mag;
            end
        end
        return t[PART_W-1:0];
    endfunction

    assign w_last = w_pipe[QUO_W];

    always_comb begin
        if (w_last.cmd == CMD_DIV) begin
            n_mag_re = REM_W'(w_last.q_re);
            n_mag_im = REM_W'(w_last.q_im);
        end else begin
            n_mag_re = w_last.rem_re;
            n_mag_im = w_last.rem_im;
        end
        n_res.res_real = sat_part(w_last.neg_re, n_mag_re, n_ovf_re);
        n_res.res_imag = sat_part(w_last.neg_im, n_mag_im, n_ovf_im);
        n_res.overflow = n_ovf_re | n_ovf_im;
        n_res.div_zero = w_last.dz;
        if (w_last.dz) begin
            n_res.res_real = '0;
            n_res.res_imag = '0;
            n_res.overflow = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_last.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule
